// File: sv/lphs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared widths, codes, mixing constants and the controller/datapath link
// types of the linear probing hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

  localparam int unsigned CMD_W           = 2;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned SLOT_W          = 8;
  localparam int unsigned TABLE_SLOTS_DEF = 256;

  // SplitMix64 finaliser
  localparam logic [KEY_W-1:0] MIX_C1  = 64'hbf58476d1ce4e5b9;
  localparam logic [KEY_W-1:0] MIX_C2  = 64'h94d049bb133111eb;
  localparam int unsigned      MIX_SH0 = 30;
  localparam int unsigned      MIX_SH1 = 27;
  localparam int unsigned      MIX_SH2 = 31;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ABSENT   = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_A,
    DP_MUL_B,
    DP_MUL_C,
    DP_XS,
    DP_RD,
    DP_NEXT,
    DP_INS,
    DP_SWEEP,
    DP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   round;
    logic   use_slot;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic match;
    logic last;
    logic is_add;
    logic is_clear;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: sv/lphs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphs_req_if
// Request channel: command and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lphs_req_if;
  import lphs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);

endinterface
`default_nettype wire

// File: sv/lphs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphs_rsp_if
// Response channel: status and slot, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lphs_rsp_if;
  import lphs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);

endinterface
`default_nettype wire

// File: sv/lphs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphs_dp
// Datapath: key hash over a shared 32x32 multiplier, slot table memory,
// probe pointer and counter, response slot register.
// ----------------------------------------------------------------------------
module lphs_dp #(
  parameter int unsigned TableSlots = lphs_pkg::TABLE_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [lphs_pkg::CMD_W-1:0]       req_cmd_i,
  input  logic signed [lphs_pkg::KEY_W-1:0] req_key_i,
  input  lphs_pkg::dp_cmd_t                cmd_i,
  output lphs_pkg::dp_sts_t                sts_o,
  output logic [lphs_pkg::SLOT_W-1:0]      rsp_slot_o
);
  import lphs_pkg::*;

  localparam int unsigned IdxW  = $clog2(TableSlots);
  localparam int unsigned WordW = KEY_W + 1;

  logic [KEY_W-1:0]  key_u;
  logic [KEY_W-1:0]  load_z;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  z_q;
  logic [KEY_W-1:0]  acc_q;
  logic [KEY_W-1:0]  xs;
  logic [KEY_W-1:0]  mul_c;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       prod;
  logic [CMD_W-1:0]  cmd_q;
  logic [IdxW-1:0]   pos_q;
  logic [IdxW-1:0]   pos_nx;
  logic [IdxW-1:0]   cnt_q;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   wr_addr;
  logic [WordW-1:0]  wr_data;
  logic [WordW-1:0]  rd_q;
  logic              wr_en;
  logic              rd_en;
  logic [SLOT_W-1:0] slot_q;

  // bit KEY_W is the valid flag
  logic [WordW-1:0]  mem [TableSlots];

  assign key_u  = req_key_i;
  assign load_z = key_u ^ (key_u >> MIX_SH0);

  // low 64 bits of z * C from three 32x32 partial products
  assign mul_c = cmd_i.round ? MIX_C2 : MIX_C1;
  assign mul_a = (cmd_i.op == DP_MUL_B) ? z_q[63:32] : z_q[31:0];
  assign mul_b = (cmd_i.op == DP_MUL_C) ? mul_c[63:32] : mul_c[31:0];
  assign prod  = mul_a * mul_b;

  assign xs = cmd_i.round ? (acc_q ^ (acc_q >> MIX_SH2))
                          : (acc_q ^ (acc_q >> MIX_SH1));

  assign pos_nx = pos_q + IdxW'(1);

  assign wr_en   = (cmd_i.op == DP_INS) || (cmd_i.op == DP_SWEEP);
  assign wr_addr = (cmd_i.op == DP_SWEEP) ? cnt_q : pos_q;
  assign wr_data = {(cmd_i.op == DP_INS), key_q};
  assign rd_en   = (cmd_i.op == DP_RD) || (cmd_i.op == DP_NEXT);
  assign rd_addr = (cmd_i.op == DP_NEXT) ? pos_nx : pos_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        key_q <= key_u;
        cmd_q <= req_cmd_i;
        z_q   <= load_z;
      end
      DP_MUL_A: begin
        acc_q <= prod;
      end
      DP_MUL_B, DP_MUL_C: begin
        acc_q[63:32] <= acc_q[63:32] + prod[31:0];
      end
      DP_XS: begin
        z_q <= xs;
        if (cmd_i.round) begin
          pos_q <= xs[IdxW-1:0];
        end
      end
      DP_NEXT: begin
        pos_q <= pos_nx;
      end
      DP_PUSH: begin
        slot_q <= cmd_i.use_slot ? SLOT_W'(pos_q) : '0;
      end
      default: begin
      end
    endcase
  end

  // probe count during a walk, address during a sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      priority if (cmd_i.op == DP_LOAD || (cmd_i.op == DP_XS && cmd_i.round)) begin
        cnt_q <= '0;
      end else if (cmd_i.op == DP_NEXT || cmd_i.op == DP_SWEEP) begin
        cnt_q <= cnt_q + IdxW'(1);
      end else begin
        cnt_q <= cnt_q;
      end
    end
  end

  assign sts_o.empty    = !rd_q[KEY_W];
  assign sts_o.match    = (rd_q[KEY_W-1:0] == key_q);
  assign sts_o.last     = &cnt_q;
  assign sts_o.is_add   = (cmd_q == CMD_ADD);
  assign sts_o.is_clear = (cmd_q == CMD_CLEAR);

  assign rsp_slot_o = slot_q;

endmodule
`default_nettype wire

// File: sv/lphs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphs_ctrl
// Controller: sequences hash, probe walk, insert and sweep; owns the
// request/response handshakes and the response status register.
// ----------------------------------------------------------------------------
module lphs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [lphs_pkg::STATUS_W-1:0] rsp_status_o,
  input  lphs_pkg::dp_sts_t             sts_i,
  output lphs_pkg::dp_cmd_t             cmd_o
);
  import lphs_pkg::*;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_DEC,
    S_MA,
    S_MB,
    S_MC,
    S_XS,
    S_RD,
    S_CHK,
    S_NEXT,
    S_INS,
    S_RESP
  } state_e;

  state_e  state_q;
  logic    round_q;
  logic    report_q;
  status_e res_q;
  logic    use_slot_q;
  logic    rsp_valid_q;
  status_e rsp_status_q;
  logic    out_free;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.round    = round_q;
    cmd_o.use_slot = use_slot_q;
    unique case (state_q)
      S_SWEEP: cmd_o.op = DP_SWEEP;
      S_IDLE:  cmd_o.op = req_valid_i ? DP_LOAD : DP_NOP;
      S_DEC:   cmd_o.op = DP_NOP;
      S_MA:    cmd_o.op = DP_MUL_A;
      S_MB:    cmd_o.op = DP_MUL_B;
      S_MC:    cmd_o.op = DP_MUL_C;
      S_XS:    cmd_o.op = DP_XS;
      S_RD:    cmd_o.op = DP_RD;
      S_CHK:   cmd_o.op = DP_NOP;
      S_NEXT:  cmd_o.op = DP_NEXT;
      S_INS:   cmd_o.op = DP_INS;
      S_RESP:  cmd_o.op = out_free ? DP_PUSH : DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      round_q      <= 1'b0;
      report_q     <= 1'b0;
      res_q        <= ST_ABSENT;
      use_slot_q   <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= ST_ABSENT;
    end else begin
      if (state_q == S_RESP && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_SWEEP: begin
          if (sts_i.last) begin
            if (report_q) begin
              res_q      <= ST_CLEARED;
              use_slot_q <= 1'b0;
              state_q    <= S_RESP;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (sts_i.is_clear) begin
            report_q <= 1'b1;
            state_q  <= S_SWEEP;
          end else begin
            round_q <= 1'b0;
            state_q <= S_MA;
          end
        end
        S_MA: state_q <= S_MB;
        S_MB: state_q <= S_MC;
        S_MC: state_q <= S_XS;
        S_XS: begin
          if (round_q) begin
            state_q <= S_RD;
          end else begin
            round_q <= 1'b1;
            state_q <= S_MA;
          end
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          priority if (sts_i.empty) begin
            if (sts_i.is_add) begin
              state_q <= S_INS;
            end else begin
              res_q      <= ST_ABSENT;
              use_slot_q <= 1'b0;
              state_q    <= S_RESP;
            end
          end else if (sts_i.match) begin
            res_q      <= ST_PRESENT;
            use_slot_q <= 1'b1;
            state_q    <= S_RESP;
          end else if (sts_i.last) begin
            res_q      <= sts_i.is_add ? ST_FULL : ST_ABSENT;
            use_slot_q <= 1'b0;
            state_q    <= S_RESP;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: state_q <= S_CHK;
        S_INS: begin
          res_q      <= ST_INSERTED;
          use_slot_q <= 1'b1;
          state_q    <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            rsp_status_q <= res_q;
            state_q      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;

endmodule
`default_nettype wire

// File: sv/linear_probe_hash_set.sv
// Requests: one at a time; req ready is high only while idle, so a new request is taken
//   only after the response to the last one has been issued.
// The key hash makes 6 passes over the shared 32x32 multiplier; each probe reads the
//   slot memory and then checks the slot.
// Reset: asynchronous, active low; afterwards a sweep empties every slot of the
//   table while req ready stays low.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Hash set of 64-bit keys in a power-of-two table with linear probing:
// lookup, add and clear, one response beat per request beat.
// ----------------------------------------------------------------------------
module linear_probe_hash_set #(
  parameter int unsigned TABLE_SLOTS = lphs_pkg::TABLE_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lphs_req_if.sink          req_i,
  lphs_rsp_if.source        rsp_o
);
  import lphs_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  lphs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .sts_i        (dp_sts),
    .cmd_o        (dp_cmd)
  );

  lphs_dp #(
    .TableSlots (TABLE_SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_cmd_i  (req_i.cmd),
    .req_key_i  (req_i.key),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .rsp_slot_o (rsp_o.slot)
  );

endmodule
`default_nettype wire
